[sv/k_group_stream_reverser_macros.svh]
// Assertion helpers for the group reverser
`ifndef K_GROUP_STREAM_REVERSER_MACROS_SVH
`define K_GROUP_STREAM_REVERSER_MACROS_SVH

// Checked only while out of reset
`define KGSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included
`define KGSR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/kgsr_pkg.sv]
`default_nettype none
package kgsr_pkg;

    localparam int MAX_GROUP_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int GS_WIDTH       = 5;
    localparam logic [GS_WIDTH-1:0] GS_RESET = 5'd1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic load;
        logic last;
        logic list_end;
    } t_load;

endpackage
`default_nettype wire

[sv/kgsr_buf.sv]
`default_nettype none
module kgsr_buf #(
    parameter int MAX_GROUP  = kgsr_pkg::MAX_GROUP_DEF,
    parameter int DATA_WIDTH = kgsr_pkg::DATA_WIDTH_DEF,
    localparam int AW = $clog2(MAX_GROUP)
) (
    input  wire logic                  i_clk,
    input  wire kgsr_pkg::t_mem_ctl    i_ctl,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire logic [DATA_WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0]      o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [MAX_GROUP];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[sv/kgsr_seq.sv]
`default_nettype none
module kgsr_seq #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF,
    localparam int AW = $clog2(MAX_GROUP),
    localparam int CW = $clog2(MAX_GROUP + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [kgsr_pkg::GS_WIDTH-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_list_end,
    input  wire logic                          i_out_free,
    output logic                               o_in_stall,
    output kgsr_pkg::t_mem_ctl                 o_ctl,
    output logic [AW-1:0]                      o_wr_addr,
    output logic [AW-1:0]                      o_rd_addr,
    output kgsr_pkg::t_load                    o_load
);

    kgsr_pkg::t_state              r_state, n_state;
    logic [CW-1:0]                 r_fill, n_fill;
    logic [kgsr_pkg::GS_WIDTH-1:0] r_gs;
    logic [AW-1:0]                 r_ptr, n_ptr;
    logic [AW-1:0]                 r_rem, n_rem;
    logic                          r_rev, n_rev;
    logic                          r_end, n_end;
    logic [CW-1:0]                 k_eff;
    logic [CW-1:0]                 fill_inc;
    logic                          in_fire;
    logic                          hit;
    logic                          load_now;

    always_comb begin
        if (r_gs == '0) begin
            k_eff = CW'(1);
        end else if (int'(r_gs) > MAX_GROUP) begin
            k_eff = CW'(MAX_GROUP);
        end else begin
            k_eff = CW'(r_gs);
        end
    end

    assign o_in_stall = (r_state != kgsr_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && (r_state == kgsr_pkg::ST_IDLE);
    assign fill_inc   = r_fill + CW'(1);
    assign hit        = (fill_inc >= k_eff);
    assign load_now   = (r_state == kgsr_pkg::ST_LOAD) && i_out_free;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_ptr        = r_ptr;
        n_rem        = r_rem;
        n_rev        = r_rev;
        n_end        = r_end;
        o_ctl.wr_en  = 1'b0;
        o_ctl.rd_en  = 1'b0;
        case (r_state)
            kgsr_pkg::ST_IDLE: begin
                if (in_fire) begin
                    o_ctl.wr_en = 1'b1;
                    if (hit || i_list_end) begin
                        n_fill  = '0;
                        n_rem   = AW'(r_fill);
                        n_rev   = hit;
                        n_ptr   = hit ? AW'(r_fill) : '0;
                        n_end   = i_list_end;
                        n_state = kgsr_pkg::ST_READ;
                    end else begin
                        n_fill = fill_inc;
                    end
                end
            end
            kgsr_pkg::ST_READ: begin
                o_ctl.rd_en = 1'b1;
                n_state     = kgsr_pkg::ST_LOAD;
            end
            kgsr_pkg::ST_LOAD: begin
                if (i_out_free) begin
                    if (r_rem == '0) begin
                        n_state = kgsr_pkg::ST_IDLE;
                    end else begin
                        // advance and fetch the next word
                        o_ctl.rd_en = 1'b1;
                        n_ptr       = r_rev ? r_ptr - AW'(1) : r_ptr + AW'(1);
                        n_rem       = r_rem - AW'(1);
                    end
                end
            end
            default: begin
                n_state = kgsr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_wr_addr       = AW'(r_fill);
    assign o_rd_addr       = n_ptr;
    assign o_load.load     = load_now;
    assign o_load.last     = (r_rem == '0);
    assign o_load.list_end = (r_rem == '0) && r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kgsr_pkg::ST_IDLE;
            r_fill  <= '0;
            r_gs    <= kgsr_pkg::GS_RESET;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_valid) begin
                r_gs <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_rem <= n_rem;
        r_rev <= n_rev;
        r_end <= n_end;
    end

endmodule
`default_nettype wire

[sv/k_group_stream_reverser.sv]
// channel   direction  handshake        payload
// in        input      valid / stall    value, list_end
// out       output     valid / stall    out_value, run_last, out_list_end
// cfg       input      valid / ready    group_size (5 bits), always ready
//
// An item that holds a word back is only written to the group buffer. An item that
// closes a group or ends the list is written, then the first buffer read is made,
// then the words are emitted one by one through the single read port of the buffer.
// Input is stalled from the closing item until the last word of its run is
// loaded into the output register. Output stall holds that register and the
// pending read. Reset is synchronous; it empties the group and sets the size to 1.
`default_nettype none
module k_group_stream_reverser #(
    parameter int MAX_GROUP  = kgsr_pkg::MAX_GROUP_DEF,
    parameter int DATA_WIDTH = kgsr_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [kgsr_pkg::GS_WIDTH-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [DATA_WIDTH-1:0]  i_value,
    input  wire logic                          i_list_end,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [DATA_WIDTH-1:0]       o_out_value,
    output logic                               o_run_last,
    output logic                               o_out_list_end
);

    localparam int AW = $clog2(MAX_GROUP);

    kgsr_pkg::t_mem_ctl    mem_ctl;
    kgsr_pkg::t_load       load;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  out_free;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic                  r_out_last;
    logic                  r_out_end;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    kgsr_seq #(
        .MAX_GROUP (MAX_GROUP)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_list_end  (i_list_end),
        .i_out_free  (out_free),
        .o_in_stall  (o_in_stall),
        .o_ctl       (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .o_load      (load)
    );

    kgsr_buf #(
        .MAX_GROUP  (MAX_GROUP),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load.load) begin
            r_out_value <= rd_data;
            r_out_last  <= load.last;
            r_out_end   <= load.list_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_value    = r_out_value;
    assign o_run_last     = r_out_last;
    assign o_out_list_end = r_out_end;

endmodule
`default_nettype wire

[sv/kgsr_chk.sv]
`default_nettype none
`include "k_group_stream_reverser_macros.svh"
module kgsr_chk #(
    parameter int DATA_WIDTH = kgsr_pkg::DATA_WIDTH_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          i_list_end,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic signed [DATA_WIDTH-1:0]  o_out_value,
    input wire logic                          o_run_last,
    input wire logic                          o_out_list_end
);

    `KGSR_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_value) && $stable(o_run_last) && $stable(o_out_list_end), "stalled output word changed")
    `KGSR_ASSERT(a_end_is_last, o_out_valid && o_out_list_end |-> o_run_last, "list end outside run end")
    `KGSR_ASSERT(a_end_flushes, i_in_valid && !o_in_stall && i_list_end |=> o_in_stall, "list end did not start a flush")
    `KGSR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind k_group_stream_reverser kgsr_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);
`default_nettype wire

[tb/sv/k_group_stream_reverser_tb.sv]
`default_nettype none
module k_group_stream_reverser_tb;

    localparam int MAX_GROUP     = kgsr_pkg::MAX_GROUP_DEF;
    localparam int DATA_WIDTH    = kgsr_pkg::DATA_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    typedef struct {
        t_word value;
        logic  run_last;
        logic  list_end;
    } t_reordered_word;

    class t_group_order_tracker;
        logic [kgsr_pkg::GS_WIDTH-1:0] group_size;
        t_word                         held_words[MAX_GROUP];
        int                            held_count;
        t_reordered_word               reordered_q[$];
        int                            mismatches;
        int                            words_checked;

        function new();
            group_size    = kgsr_pkg::GS_RESET;
            held_count    = 0;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void set_size(logic [kgsr_pkg::GS_WIDTH-1:0] size);
            group_size = size;
        endfunction

        function int pending();
            return reordered_q.size();
        endfunction

        function void queue_word(t_word value, logic run_last, logic list_end);
            t_reordered_word w;
            w.value    = value;
            w.run_last = run_last;
            w.list_end = run_last & list_end;
            reordered_q.push_back(w);
        endfunction

        function void take_word(t_word value, logic list_end);
            int k;
            int i;
            k = (group_size == 0) ? 1 : (group_size > MAX_GROUP) ? MAX_GROUP : group_size;
            if (held_count < MAX_GROUP) begin
                held_words[held_count] = value;
                held_count++;
            end
            if (held_count >= k) begin
                for (i = held_count - 1; i >= 0; i--) begin
                    queue_word(held_words[i], i == 0, list_end);
                end
                held_count = 0;
            end else if (list_end) begin
                for (i = 0; i < held_count; i++) begin
                    queue_word(held_words[i], i == held_count - 1, list_end);
                end
                held_count = 0;
            end
        endfunction

        function void check_word(t_word value, logic run_last, logic list_end);
            t_reordered_word w;
            words_checked++;
            if (reordered_q.size() == 0) begin
                $error("unexpected word: out_value %0d run_last %0b out_list_end %0b",
                       value, run_last, list_end);
                mismatches++;
                return;
            end
            w = reordered_q.pop_front();
            if (value !== w.value) begin
                $error("out_value: expected %0d, got %0d", w.value, value);
                mismatches++;
            end
            if (run_last !== w.run_last) begin
                $error("run_last: expected %0b, got %0b", w.run_last, run_last);
                mismatches++;
            end
            if (list_end !== w.list_end) begin
                $error("out_list_end: expected %0b, got %0b", w.list_end, list_end);
                mismatches++;
            end
        endfunction
    endclass

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_valid  = 1'b0;
    logic [kgsr_pkg::GS_WIDTH-1:0] i_cfg_data   = '0;
    logic                          i_in_valid   = 1'b0;
    t_word                         i_value      = '0;
    logic                          i_list_end   = 1'b0;
    logic                          i_out_stall  = 1'b0;
    logic                          o_cfg_ready;
    logic                          o_in_stall;
    logic                          o_out_valid;
    t_word                         o_out_value;
    logic                          o_run_last;
    logic                          o_out_list_end;

    t_group_order_tracker tracker;
    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    int                   cycle_count   = 0;
    int                   words_sent    = 0;
    int                   sizes_written = 0;

    k_group_stream_reverser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_list_end     (i_list_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_value    (o_out_value),
        .o_run_last     (o_run_last),
        .o_out_list_end (o_out_list_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_word(o_out_value, o_run_last, o_out_list_end);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("k_group_stream_reverser_tb failed");
            $finish;
        end
    end

    function automatic t_word pick_value();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int effective_size(logic [kgsr_pkg::GS_WIDTH-1:0] size);
        return (size == 0) ? 1 : (size > MAX_GROUP) ? MAX_GROUP : size;
    endfunction

    task automatic push_word(t_word value, logic list_end);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        i_list_end <= list_end;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_word(value, list_end);
        words_sent++;
    endtask

    // hold input until every reordered word is out, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_group_size(logic [kgsr_pkg::GS_WIDTH-1:0] size);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_size(size);
        sizes_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_list(int len);
        int   j;
        logic last;
        for (j = 0; j < len; j++) begin
            last = (j == len - 1);
            if ($urandom_range(0, 9) == 0) begin
                last = ~last;
            end
            push_word(pick_value(), last);
        end
    endtask

    logic [kgsr_pkg::GS_WIDTH-1:0] size_plan[13] = '{5'd16, 5'd2, 5'd31, 5'd7, 5'd1, 5'd0,
                                                    5'd4, 5'd17, 5'd12, 5'd3, 5'd9, 5'd5,
                                                    5'd16};

    initial begin
        int seg;
        int seg_words;
        int k;
        tracker = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through at the reset size, extremes of the value range
        push_word({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b0);
        push_word({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b0);
        push_word('0, 1'b1);
        push_word('1, 1'b1);
        settle();
        write_group_size(5'd0);
        push_word(32'h5a5a_a5a5, 1'b0);
        settle();
        // full group on the final word, then a short list left partly filled
        write_group_size(5'd3);
        push_word(32'd11, 1'b0);
        push_word(32'd22, 1'b0);
        push_word(-32'sd33, 1'b1);
        push_word(32'd44, 1'b0);
        push_word(32'd55, 1'b1);
        settle();
        // shrink the group while words are held
        write_group_size(5'd5);
        push_word(32'd101, 1'b0);
        push_word(32'd102, 1'b0);
        push_word(32'd103, 1'b0);
        settle();
        write_group_size(5'd2);
        push_word(32'd104, 1'b0);
        settle();

        for (seg = 0; seg < 13; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 65; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            write_group_size(size_plan[seg]);
            k = effective_size(size_plan[seg]);
            seg_words = 0;
            while (seg_words < 5) begin
                if ($urandom_range(0, 4) == 0) begin
                    seg_words += 1;
                    send_list(1);
                end else begin
                    int len;
                    len = $urandom_range(1, k + 2);
                    seg_words += len;
                    send_list(len);
                end
            end
            settle();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        settle();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d words over %0d group size writes; checked %0d reordered words.",
                 words_sent, sizes_written, tracker.words_checked);
        $display("Sizes 0 to 31 incl. saturation, idle and stall mixes, mid-group resizing.");
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("k_group_stream_reverser_tb passed");
        end else begin
            $display("k_group_stream_reverser_tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
